// ----- rtl/core/ctkd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ctkd_pkg
// shared types and constants of the capacitive touch key detector
// ----------------------------------------------------------------------------
package ctkd_pkg;

	// default parameter values
	localparam int CALIB_SAMPLES_DEF = 16;
	localparam int COUNT_WIDTH_DEF   = 16;

	// fixed field widths
	localparam int THRESH_W   = 15;
	localparam int HOLD_W     = 8;
	localparam int DELTA_W    = 15;
	localparam int BASELINE_W = 16;
	localparam int CFG_DATA_W = 15;
	localparam int CFG_IDX_W  = 1;

	// register reset values
	localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(150);
	localparam logic [HOLD_W-1:0]   HOLD_RESET   = HOLD_W'(20);

	// largest reportable delta
	localparam logic [DELTA_W-1:0] DELTA_MAX = {DELTA_W{1'b1}};

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KEY_THRESHOLD = 1'b0,
		REG_HOLD_SAMPLES  = 1'b1
	} ctkd_reg_e;

	// one result item
	typedef struct packed {
		logic                  calibrating;
		logic                  pressed;
		logic [DELTA_W-1:0]    delta;
		logic                  slow_rate;
		logic                  led_on;
		logic [BASELINE_W-1:0] baseline;
	} ctkd_result_t;

endpackage : ctkd_pkg
`default_nettype wire

// ----- rtl/core/capacitive_touch_key_detector_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// capacitive_touch_key_detector_top
// touch key detector with baseline calibration, tracking and press hold
// ----------------------------------------------------------------------------
//  channel | signals                                  | direction
//  --------+------------------------------------------+----------
//  in      | in_valid, in_stall, count                | sample in
//  out     | out_valid, out_stall, calibrating,       | result out
//          | pressed, delta, slow_rate, led_on,       |
//          | baseline                                 |
//  cfg     | cfg_we, cfg_index, cfg_data              | register write
//
//  one sample per cycle sustained while the result is not stalled; a sample
//  passes the input register, then the result register, and the result
//  transfers when it is valid and not stalled
//  the baseline/hold/led state updates as a sample moves into the result
//  register, so the next sample already sees it
//  a stalled result holds the input register; the input side stalls only
//  when both stages are full and the result is stalled
//  reset clears both stage valids, hold and led state and the baseline,
//  reloads the calibration count and the config register defaults
// ----------------------------------------------------------------------------
module capacitive_touch_key_detector_top #(
	parameter int CALIB_SAMPLES = ctkd_pkg::CALIB_SAMPLES_DEF,
	parameter int COUNT_WIDTH   = ctkd_pkg::COUNT_WIDTH_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// sample input
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic [COUNT_WIDTH-1:0]          count,
	// result output
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic                                 calibrating,
	output logic                                 pressed,
	output logic [ctkd_pkg::DELTA_W-1:0]         delta,
	output logic                                 slow_rate,
	output logic                                 led_on,
	output logic [ctkd_pkg::BASELINE_W-1:0]      baseline,
	// configuration writes
	input  wire logic                            cfg_we,
	input  wire logic [ctkd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [ctkd_pkg::CFG_DATA_W-1:0] cfg_data
);
	import ctkd_pkg::*;

	localparam int CAL_W = $clog2(CALIB_SAMPLES + 1);

	// config registers
	logic [THRESH_W-1:0]    key_threshold_q;
	logic [HOLD_W-1:0]      hold_samples_q;

	// tracking state
	logic [COUNT_WIDTH-1:0] base_level_q;
	logic [CAL_W-1:0]       calib_left_q;
	logic [HOLD_W-1:0]      hold_left_q;
	logic                   led_state_q;

	// input stage
	logic                   valid_s1;
	logic [COUNT_WIDTH-1:0] count_s1;

	// result stage
	logic                   valid_s2;
	ctkd_result_t           res_s2;

	// next-state from the update logic
	logic [COUNT_WIDTH-1:0] base_nxt;
	logic [CAL_W-1:0]       calib_nxt;
	logic [HOLD_W-1:0]      hold_nxt;
	logic                   led_nxt;
	ctkd_result_t           res_nxt;

	logic                   advance;
	logic                   in_xfer;

	// the input stage moves on when the result slot is free or being drained
	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_xfer  = in_valid && !in_stall;

	// config writes, unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_threshold_q <= THRESH_RESET;
			hold_samples_q  <= HOLD_RESET;
		end else if (cfg_we) begin
			case (ctkd_reg_e'(cfg_index))
				REG_KEY_THRESHOLD: key_threshold_q <= cfg_data[THRESH_W-1:0];
				REG_HOLD_SAMPLES:  hold_samples_q  <= cfg_data[HOLD_W-1:0];
				default: ;
			endcase
		end
	end

	// input stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// input stage payload
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			count_s1 <= count;
		end
	end

	ctkd_update #(
		.CALIB_SAMPLES (CALIB_SAMPLES),
		.COUNT_WIDTH   (COUNT_WIDTH)
	) u_update (
		.count         (count_s1),
		.key_threshold (key_threshold_q),
		.hold_samples  (hold_samples_q),
		.base_cur      (base_level_q),
		.calib_cur     (calib_left_q),
		.hold_cur      (hold_left_q),
		.led_cur       (led_state_q),
		.base_nxt      (base_nxt),
		.calib_nxt     (calib_nxt),
		.hold_nxt      (hold_nxt),
		.led_nxt       (led_nxt),
		.result        (res_nxt)
	);

	// state commits together with the result transfer into stage two
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_level_q <= '0;
			calib_left_q <= CAL_W'(CALIB_SAMPLES);
			hold_left_q  <= '0;
			led_state_q  <= 1'b0;
		end else if (advance) begin
			base_level_q <= base_nxt;
			calib_left_q <= calib_nxt;
			hold_left_q  <= hold_nxt;
			led_state_q  <= led_nxt;
		end
	end

	// result stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	// result stage payload
	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_nxt;
		end
	end

	assign out_valid   = valid_s2;
	assign calibrating = res_s2.calibrating;
	assign pressed     = res_s2.pressed;
	assign delta       = res_s2.delta;
	assign slow_rate   = res_s2.slow_rate;
	assign led_on      = res_s2.led_on;
	assign baseline    = res_s2.baseline;

	// a calibration result reports no key activity
	a_calib_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.calibrating) |->
			(!res_s2.pressed && !res_s2.slow_rate && res_s2.delta == '0))
		else $error("calibration result carries key activity");

	// a press never selects the slow rate
	a_press_fast: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.pressed) |-> !res_s2.slow_rate)
		else $error("press reported with slow rate");

	// once a tracking result is out, calibration is over for good
	a_calib_done: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !res_s2.calibrating) |-> (calib_left_q == '0))
		else $error("tracking result while calibration pending");

	// a press reloads the hold counter from the register
	a_hold_reload: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && res_nxt.pressed) |=> (hold_left_q == $past(hold_samples_q)))
		else $error("hold counter not reloaded on press");

	// stage one is never overwritten while it waits
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(count_s1)))
		else $error("waiting sample lost");

endmodule : capacitive_touch_key_detector_top
`default_nettype wire

// ----- rtl/core/ctkd_update.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ctkd_update
// per-sample next-state and result logic (purely combinational)
// ----------------------------------------------------------------------------
module ctkd_update #(
	parameter int CALIB_SAMPLES = ctkd_pkg::CALIB_SAMPLES_DEF,
	parameter int COUNT_WIDTH   = ctkd_pkg::COUNT_WIDTH_DEF,
	localparam int CAL_W        = $clog2(CALIB_SAMPLES + 1)
) (
	input  wire logic [COUNT_WIDTH-1:0]        count,
	input  wire logic [ctkd_pkg::THRESH_W-1:0] key_threshold,
	input  wire logic [ctkd_pkg::HOLD_W-1:0]   hold_samples,
	input  wire logic [COUNT_WIDTH-1:0]        base_cur,
	input  wire logic [CAL_W-1:0]              calib_cur,
	input  wire logic [ctkd_pkg::HOLD_W-1:0]   hold_cur,
	input  wire logic                          led_cur,
	output logic      [COUNT_WIDTH-1:0]        base_nxt,
	output logic      [CAL_W-1:0]              calib_nxt,
	output logic      [ctkd_pkg::HOLD_W-1:0]   hold_nxt,
	output logic                               led_nxt,
	output ctkd_pkg::ctkd_result_t             result
);
	import ctkd_pkg::*;

	localparam int CMP_W  = (COUNT_WIDTH > THRESH_W) ? COUNT_WIDTH : THRESH_W;
	localparam int BEXT_W = (COUNT_WIDTH > BASELINE_W) ? COUNT_WIDTH : BASELINE_W;

	logic [COUNT_WIDTH:0]   sum;
	logic [COUNT_WIDTH-1:0] avg;
	logic [COUNT_WIDTH-1:0] diff;
	logic [COUNT_WIDTH-1:0] diff_pos;
	logic [COUNT_WIDTH-1:0] base_adj;
	logic [CMP_W-1:0]       diff_ext;
	logic                   press;
	logic [BEXT_W-1:0]      base_ext;

	// shared datapath: (COUNT_WIDTH+1)-bit average sum and wrapped difference
	assign sum      = {1'b0, base_cur} + {1'b0, count};
	assign avg      = sum[COUNT_WIDTH:1];
	assign diff     = base_cur - count;
	// difference sign bit set (read as count above baseline): re-average and clamp
	assign diff_pos = diff[COUNT_WIDTH-1] ? '0 : diff;
	assign base_adj = diff[COUNT_WIDTH-1] ? avg : base_cur;
	assign diff_ext = CMP_W'(diff_pos);
	assign press    = diff_ext > CMP_W'(key_threshold);

	always_comb begin
		base_nxt           = base_cur;
		calib_nxt          = calib_cur;
		hold_nxt           = hold_cur;
		led_nxt            = led_cur;
		result.calibrating = 1'b0;
		result.pressed     = 1'b0;
		result.delta       = '0;
		result.slow_rate   = 1'b0;
		if (calib_cur != '0) begin
			base_nxt           = (calib_cur == CAL_W'(CALIB_SAMPLES)) ? count : avg;
			calib_nxt          = calib_cur - CAL_W'(1);
			result.calibrating = 1'b1;
		end else begin
			if (press) begin
				result.pressed = 1'b1;
				hold_nxt       = hold_samples;
				led_nxt        = ~led_cur;
				base_nxt       = base_adj;
			end else begin
				if (hold_cur > HOLD_W'(1)) begin
					hold_nxt = hold_cur - HOLD_W'(1);
				end else begin
					hold_nxt         = '0;
					result.slow_rate = 1'b1;
				end
				led_nxt  = 1'b0;
				base_nxt = (base_adj != '0) ? base_adj - COUNT_WIDTH'(1) : '0;
			end
			result.delta = (diff_ext > CMP_W'(DELTA_MAX)) ? DELTA_MAX : diff_ext[DELTA_W-1:0];
		end
		base_ext        = BEXT_W'(base_nxt);
		result.led_on   = led_nxt;
		result.baseline = base_ext[BASELINE_W-1:0];
	end

endmodule : ctkd_update
`default_nettype wire

// ----- dv/capacitive_touch_key_detector_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// capacitive_touch_key_detector_top_tb
// self-checking bench for the touch key detector: a directed table covers
// calibration and the count extremes, then phases of touch-like random
// counts run under several threshold/hold settings, each result compared
// against its typed-in value or an in-bench model of the baseline, hold and led tracking
// ----------------------------------------------------------------------------
module capacitive_touch_key_detector_top_tb;
	import ctkd_pkg::*;

	localparam int CW         = COUNT_WIDTH_DEF;
	localparam int CALIB      = CALIB_SAMPLES_DEF;
	localparam int QUIET_MAX  = 1000;   // cycles without any transfer before giving up
	localparam int SQUEEZE_CY = 80;     // long receiver hold-off
	localparam int RES_W      = $bits(ctkd_result_t);

	// one row of the directed table: count, whether the result is typed in, result
	typedef struct packed {
		logic [CW-1:0] cnt;
		logic          known;
		ctkd_result_t  res;
	} touch_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	logic [CW-1:0]         count;
	logic                  out_valid;
	logic                  out_stall;
	logic                  calibrating;
	logic                  pressed;
	logic [DELTA_W-1:0]    delta;
	logic                  slow_rate;
	logic                  led_on;
	logic [BASELINE_W-1:0] baseline;
	logic                  cfg_we;
	ctkd_reg_e             cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// bench copy of the detector state and registers
	logic [CW-1:0]       trk_base;
	logic [4:0]          trk_calib_left;
	logic [HOLD_W-1:0]   trk_hold_left;
	logic                trk_led;
	logic [THRESH_W-1:0] thr_reg;
	logic [HOLD_W-1:0]   hold_reg;

	ctkd_result_t pending_key_results[$];
	int           errors;
	int           quiet_cycles;
	bit           idle_on;
	bit           receiver_hold;

	// directed table: reset calibration from the count extremes, then presses,
	// led toggling, a count above the baseline and sign-bit deltas
	touch_row_t directed_rows [25] = '{
		// first calibration sample loads the baseline
		{16'hFFFF, 1'b1, {1'b1, 1'b0, 15'd0, 1'b0, 1'b0, 16'hFFFF}},
		// averaging with zero halves it
		{16'h0000, 1'b1, {1'b1, 1'b0, 15'd0, 1'b0, 1'b0, 16'h7FFF}},
		{16'h8000, 1'b1, {1'b1, 1'b0, 15'd0, 1'b0, 1'b0, 16'h7FFF}},
		{16'h7FFF, 1'b0, {RES_W{1'b0}}},
		{16'h5555, 1'b0, {RES_W{1'b0}}},
		{16'hAAAA, 1'b0, {RES_W{1'b0}}},
		{16'd1000, 1'b0, {RES_W{1'b0}}},
		{16'd1000, 1'b0, {RES_W{1'b0}}},
		{16'd1000, 1'b0, {RES_W{1'b0}}},
		{16'd1000, 1'b0, {RES_W{1'b0}}},
		{16'd1000, 1'b0, {RES_W{1'b0}}},
		{16'd1000, 1'b0, {RES_W{1'b0}}},
		{16'd1000, 1'b0, {RES_W{1'b0}}},
		{16'd1000, 1'b0, {RES_W{1'b0}}},
		{16'd1000, 1'b0, {RES_W{1'b0}}},
		{16'd1000, 1'b0, {RES_W{1'b0}}},
		// tracking starts: small delta, idle rate
		{16'd1000, 1'b0, {RES_W{1'b0}}},
		// deep drops: press with led toggling each sample
		{16'h0000, 1'b0, {RES_W{1'b0}}},
		{16'h0000, 1'b0, {RES_W{1'b0}}},
		{16'h0000, 1'b0, {RES_W{1'b0}}},
		// release: led off, hold counts down
		{16'd1020, 1'b0, {RES_W{1'b0}}},
		// count far above the baseline wraps to a small difference and presses
		{16'hFFFF, 1'b0, {RES_W{1'b0}}},
		// a deep drop presses, then differences with the sign bit set read as a rise
		{16'h0000, 1'b0, {RES_W{1'b0}}},
		{16'h7FFF, 1'b0, {RES_W{1'b0}}},
		{16'h8000, 1'b0, {RES_W{1'b0}}}
	};

	capacitive_touch_key_detector_top DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.count      (count),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.calibrating(calibrating),
		.pressed    (pressed),
		.delta      (delta),
		.slow_rate  (slow_rate),
		.led_on     (led_on),
		.baseline   (baseline),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// next result of the detector for one count, advancing the bench state
	function automatic ctkd_result_t predict_key_result(input logic [CW-1:0] cnt);
		ctkd_result_t  r;
		logic [CW-1:0] diff;
		logic [CW:0]   sum;
		r = '0;
		sum = {1'b0, trk_base} + {1'b0, cnt};
		if (trk_calib_left != 0) begin
			if (trk_calib_left == 5'(CALIB))
				trk_base = cnt;
			else
				trk_base = sum[CW:1];
			trk_calib_left = trk_calib_left - 5'd1;
			r.calibrating = 1'b1;
		end else begin
			diff = trk_base - cnt;
			// difference sign bit set (read as a rise): pull the baseline up, no drop
			if (diff[CW-1]) begin
				trk_base = sum[CW:1];
				diff = '0;
			end
			if (diff > CW'(thr_reg)) begin
				r.pressed = 1'b1;
				trk_hold_left = hold_reg;
				trk_led = ~trk_led;
			end else begin
				if (trk_hold_left > 1) begin
					trk_hold_left = trk_hold_left - 1'b1;
				end else begin
					trk_hold_left = '0;
					r.slow_rate = 1'b1;
				end
				trk_led = 1'b0;
				// slow downward drift of the baseline
				if (trk_base != 0)
					trk_base = trk_base - 1'b1;
			end
			r.delta = (diff > CW'(DELTA_MAX)) ? DELTA_MAX : diff[DELTA_W-1:0];
		end
		r.led_on = trk_led;
		r.baseline = trk_base;
		return r;
	endfunction

	// one input transfer, entered and left at a falling edge; known rows
	// carry their expected result, the rest is predicted
	task automatic send_sample(input logic [CW-1:0] cnt, input logic known,
			input ctkd_result_t res);
		int           gap;
		ctkd_result_t exp_res;
		gap = (idle_on && $urandom_range(0, 4) == 0) ? $urandom_range(1, 9) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		count <= cnt;
		do @(posedge clk); while (in_stall);
		exp_res = predict_key_result(cnt);
		pending_key_results.push_back(known ? res : exp_res);
		@(negedge clk);
	endtask

	// drain, reprogram both registers, then run one phase of touch-like counts
	task automatic run_phase(input logic [CFG_DATA_W-1:0] thr_data,
			input logic [CFG_DATA_W-1:0] hold_data, input int n_items, input bit squeeze);
		int lvl;
		int c;
		int thr;
		int pick;
		in_valid <= 1'b0;
		while (pending_key_results.size() != 0) @(negedge clk);
		repeat (2) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= REG_KEY_THRESHOLD;
		cfg_data <= thr_data;
		@(negedge clk);
		cfg_index <= REG_HOLD_SAMPLES;
		cfg_data <= hold_data;
		@(negedge clk);
		cfg_we <= 1'b0;
		thr_reg = thr_data[THRESH_W-1:0];
		hold_reg = hold_data[HOLD_W-1:0];
		receiver_hold = squeeze;
		thr = int'(thr_reg);
		lvl = $urandom_range(thr + 500, 65535);
		for (int i = 0; i < n_items; i++) begin
			// the resting level moves now and then
			if ($urandom_range(0, 49) == 0)
				lvl = $urandom_range(thr + 500, 65535);
			pick = $urandom_range(0, 19);
			if (pick == 0)
				c = $urandom_range(0, 65535);                          // noise
			else if (pick <= 8)
				c = lvl - (thr + $urandom_range(0, 400) - 20);          // touch near/over threshold
			else if (pick <= 11)
				c = lvl + $urandom_range(0, 100);                       // drift up
			else
				c = lvl - $urandom_range(0, thr);                       // untouched jitter
			if (c < 0)
				c = 0;
			else if (c > 65535)
				c = 65535;
			send_sample(CW'(c), 1'b0, '0);
		end
	endtask

	// receiver: random stall bursts, or one long hold-off on request
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (receiver_hold) begin
				receiver_hold = 1'b0;
				out_stall <= 1'b1;
				repeat (SQUEEZE_CY) @(negedge clk);
				out_stall <= 1'b0;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 9)) @(negedge clk);
				out_stall <= 1'b0;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// result checking and transfer activity for the watchdog
	always @(posedge clk) begin
		ctkd_result_t got;
		ctkd_result_t want;
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
			quiet_cycles = 0;
		else
			quiet_cycles = quiet_cycles + 1;
		if (arst_n && out_valid && !out_stall) begin
			got = {calibrating, pressed, delta, slow_rate, led_on, baseline};
			if (pending_key_results.size() == 0) begin
				$error("result transfer with nothing expected: %h", got);
				errors++;
			end else begin
				want = pending_key_results.pop_front();
				if (got.calibrating !== want.calibrating) begin
					$error("calibrating: expected %0d, got %0d", want.calibrating,
						got.calibrating);
					errors++;
				end
				if (got.pressed !== want.pressed) begin
					$error("pressed: expected %0d, got %0d", want.pressed, got.pressed);
					errors++;
				end
				if (got.delta !== want.delta) begin
					$error("delta: expected %0d, got %0d", want.delta, got.delta);
					errors++;
				end
				if (got.slow_rate !== want.slow_rate) begin
					$error("slow_rate: expected %0d, got %0d", want.slow_rate,
						got.slow_rate);
					errors++;
				end
				if (got.led_on !== want.led_on) begin
					$error("led_on: expected %0d, got %0d", want.led_on, got.led_on);
					errors++;
				end
				if (got.baseline !== want.baseline) begin
					$error("baseline: expected %0d, got %0d", want.baseline,
						got.baseline);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles without any transfer
	initial begin
		quiet_cycles = 0;
		while (quiet_cycles < QUIET_MAX) @(posedge clk);
		$display("capacitive_touch_key_detector_top_tb failed");
		$finish;
	end

	initial begin
		errors = 0;
		idle_on = 1'b1;
		receiver_hold = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		count = '0;
		cfg_we = 1'b0;
		cfg_index = REG_KEY_THRESHOLD;
		cfg_data = '0;
		// bench state mirrors reset
		trk_base = '0;
		trk_calib_left = 5'(CALIB);
		trk_hold_left = '0;
		trk_led = 1'b0;
		thr_reg = THRESH_RESET;
		hold_reg = HOLD_RESET;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed table under reset register values
		foreach (directed_rows[i])
			send_sample(directed_rows[i].cnt, directed_rows[i].known, directed_rows[i].res);

		// zero threshold and zero hold: any drop presses, release goes slow at once
		run_phase('0, '0, 140, 1'b0);
		// top threshold, hold from masked all-ones data, with a long output hold-off
		run_phase({CFG_DATA_W{1'b1}}, {CFG_DATA_W{1'b1}}, 140, 1'b1);
		run_phase(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom), 150, 1'b0);
		// small threshold and short hold so the rate flips often
		run_phase(CFG_DATA_W'($urandom_range(20, 400)),
			CFG_DATA_W'({$urandom_range(0, 127), 8'(($urandom_range(1, 6)))}), 150, 1'b0);
		// closing stretch at full rate
		idle_on = 1'b0;
		run_phase(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom_range(1, 255)), 140, 1'b0);

		in_valid <= 1'b0;
		while (pending_key_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		if (pending_key_results.size() != 0) begin
			$error("%0d results never arrived", pending_key_results.size());
			errors++;
		end
		if (errors == 0)
			$display("capacitive_touch_key_detector_top_tb passed");
		else
			$display("capacitive_touch_key_detector_top_tb failed");
		$finish;
	end

endmodule

// ----- capacitive_touch_key_detector_top.f -----
rtl/core/ctkd_pkg.sv
rtl/core/ctkd_update.sv
rtl/core/capacitive_touch_key_detector_top.sv
dv/capacitive_touch_key_detector_top_tb.sv
